// ===== sv/bmsi_pkg.sv =====
// ---------------------------------------------------------------------------
// bmsi_pkg
// Shared types and constants for the bank mapper with scanline interrupt.
// ---------------------------------------------------------------------------
package bmsi_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN = 2'd2;
	localparam int unsigned CFG_DATA_W = 9;

	// CPU address windows, decoded on address[15:13]
	localparam logic [2:0] WIN_PRG_RAM = 3'b011;
	localparam logic [2:0] WIN_BANK    = 3'b100;
	localparam logic [2:0] WIN_MIRROR  = 3'b101;
	localparam logic [2:0] WIN_IRQ     = 3'b110;
	localparam logic [2:0] WIN_IRQ_EN  = 3'b111;

	// Bank load lengths
	localparam logic [13:0] LEN_CHR_2K = 14'h0800;
	localparam logic [13:0] LEN_CHR_1K = 14'h0400;
	localparam logic [13:0] LEN_PRG_8K = 14'h2000;

	// Bank load destinations
	localparam logic [14:0] DEST_CHR_HI  = 15'h1000;
	localparam logic [14:0] DEST_PRG_MID = 15'h2000;
	localparam logic [14:0] DEST_PRG_HI  = 15'h4000;

	// Bank load command kinds
	typedef enum logic [1:0] {
		COPY_NONE = 2'd0,
		COPY_CHR  = 2'd1,
		COPY_PRG  = 2'd2
	} bmsi_copy_kind_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_DONE
	} bmsi_state_t;

	// Configuration seen by the sequencer
	typedef struct packed {
		logic [8:0] chr_count;
		logic [8:0] prg_count;
		logic       four_screen;
	} bmsi_cfg_t;

	// Request to the modulo unit
	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [8:0] modulus;
	} bmsi_mod_req_t;

	// Response from the modulo unit
	typedef struct packed {
		logic       done;
		logic [7:0] rem;
	} bmsi_mod_rsp_t;

	// Result beat, mirroring excluded (it always shows the live flag)
	typedef struct packed {
		logic            irq_assert;
		logic            write_suppress;
		logic            swap_prg;
		bmsi_copy_kind_t copy_kind;
		logic [14:0]     copy_dest;
		logic [8:0]      copy_bank;
		logic [13:0]     copy_len;
	} bmsi_res_t;

endpackage

// ===== sv/bmsi_if.sv =====
// ---------------------------------------------------------------------------
// bmsi_in_if / bmsi_out_if
// Valid/ready channels for CPU and scanline beats in, mapper results out.
// ---------------------------------------------------------------------------
interface bmsi_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] address;
	logic [7:0]  data;

	modport source (output valid, output func, output address, output data, input ready);
	modport sink   (input valid, input func, input address, input data, output ready);
endinterface

interface bmsi_out_if;
	logic        valid;
	logic        ready;
	logic        irq_assert;
	logic        mirroring;
	logic        write_suppress;
	logic        swap_prg;
	logic [1:0]  copy_kind;
	logic [14:0] copy_dest;
	logic [8:0]  copy_bank;
	logic [13:0] copy_len;

	modport source (
		output valid, output irq_assert, output mirroring, output write_suppress,
		output swap_prg, output copy_kind, output copy_dest, output copy_bank,
		output copy_len, input ready
	);
	modport sink (
		input valid, input irq_assert, input mirroring, input write_suppress,
		input swap_prg, input copy_kind, input copy_dest, input copy_bank,
		input copy_len, output ready
	);
endinterface

// ===== sv/bmsi_mod.sv =====
// ---------------------------------------------------------------------------
// bmsi_mod
// Restoring modulo unit: one dividend bit per cycle.
// A zero modulus subtracts zero at every step, so the dividend comes back unreduced.
// ---------------------------------------------------------------------------
module bmsi_mod (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bmsi_pkg::bmsi_mod_req_t req,
	output bmsi_pkg::bmsi_mod_rsp_t rsp
);
	import bmsi_pkg::*;

	logic       run_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [7:0] dvd_q;
	logic [8:0] mod_q;
	logic [8:0] rem_q;

	logic [9:0] trial;
	logic [9:0] diff;
	logic       fits;

	// shared compare/subtract step
	assign trial = {rem_q, dvd_q[7]};
	assign diff  = trial - {1'b0, mod_q};
	assign fits  = (trial >= {1'b0, mod_q});

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 3'd7;
			end else if (run_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder and dividend shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			mod_q <= req.modulus;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[6:0], 1'b0};
			rem_q <= fits ? diff[8:0] : trial[8:0];
		end
	end

	// remainder is below 256 for an 8-bit dividend
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[7:0];

endmodule

// ===== sv/bmsi_seq.sv =====
// ---------------------------------------------------------------------------
// bmsi_seq
// Mapper state, write/clock decode, result register and item sequencer.
// ---------------------------------------------------------------------------
module bmsi_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bmsi_pkg::bmsi_cfg_t     cfg,
	bmsi_in_if.sink                 in_ch,
	bmsi_out_if.source              out_ch,
	output bmsi_pkg::bmsi_mod_req_t mod_req,
	input  bmsi_pkg::bmsi_mod_rsp_t mod_rsp
);
	import bmsi_pkg::*;

	bmsi_state_t st_q, st_d;

	// mapper state
	logic [2:0] bsel_q;
	logic       mode_swap_q;     // mode bit 6
	logic       mode_chr_inv_q;  // mode bit 7
	logic       mirror_q;
	logic       protect_q;
	logic [7:0] irq_latch_q;
	logic [9:0] irq_count_q;
	logic       irq_on_q;

	bmsi_res_t  res_q, res_d;
	logic       dbl_q, dbl_d;
	logic       bank_wr;

	logic       acc;
	logic [2:0] win;
	logic       odd;
	logic [9:0] cnt_dec;
	logic       cnt_zero;
	logic       cnt_nonpos;
	logic [2:0] bsel_m2;

	assign acc        = in_ch.valid & in_ch.ready;
	assign win        = in_ch.address[15:13];
	assign odd        = in_ch.address[0];
	assign cnt_dec    = irq_count_q - 10'd1;
	assign cnt_zero   = (cnt_dec == 10'd0);
	assign cnt_nonpos = cnt_zero | cnt_dec[9];
	assign bsel_m2    = bsel_q - 3'd2;

	// result fields decoded at accept; bank index filled in by the modulo unit
	always_comb begin
		res_d   = '0;
		bank_wr = 1'b0;
		dbl_d   = 1'b0;
		if (in_ch.func) begin
			res_d.irq_assert = cnt_zero & irq_on_q;
		end else begin
			case (win)
				WIN_BANK: begin
					if (!odd) begin
						res_d.swap_prg = in_ch.data[6] ^ mode_swap_q;
					end else begin
						bank_wr = 1'b1;
						case (bsel_q) inside
							3'd0, 3'd1: begin
								res_d.copy_kind = COPY_CHR;
								res_d.copy_dest = {3'b000, bsel_q[0], 11'b0};
								res_d.copy_len  = LEN_CHR_2K;
								dbl_d           = 1'b1;
							end
							[3'd2:3'd5]: begin
								res_d.copy_kind = COPY_CHR;
								res_d.copy_dest = DEST_CHR_HI | {3'b000, bsel_m2[1:0], 10'b0};
								res_d.copy_len  = LEN_CHR_1K;
							end
							3'd6: begin
								res_d.copy_kind = COPY_PRG;
								res_d.copy_dest = mode_swap_q ? DEST_PRG_HI : '0;
								res_d.copy_len  = LEN_PRG_8K;
								dbl_d           = 1'b1;
							end
							default: begin
								res_d.copy_kind = COPY_PRG;
								res_d.copy_dest = DEST_PRG_MID;
								res_d.copy_len  = LEN_PRG_8K;
								dbl_d           = 1'b1;
							end
						endcase
						// pattern halves trade places under mode bit 7
						if (res_d.copy_kind == COPY_CHR && mode_chr_inv_q)
							res_d.copy_dest = res_d.copy_dest ^ DEST_CHR_HI;
					end
				end
				WIN_PRG_RAM: res_d.write_suppress = protect_q;
				default: ;
			endcase
		end
	end

	// modulo request for bank data writes
	assign mod_req.start    = acc & bank_wr;
	assign mod_req.dividend = in_ch.data;
	assign mod_req.modulus  = (bsel_q[2:1] == 2'b11) ? cfg.prg_count : cfg.chr_count;

	// mapper state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsel_q         <= '0;
			mode_swap_q    <= 1'b0;
			mode_chr_inv_q <= 1'b0;
			mirror_q       <= 1'b0;
			protect_q      <= 1'b0;
			irq_latch_q    <= '0;
			irq_count_q    <= '0;
			irq_on_q       <= 1'b0;
		end else if (acc) begin
			if (in_ch.func) begin
				irq_count_q <= cnt_nonpos ? {2'b00, irq_latch_q} : cnt_dec;
			end else begin
				case (win)
					WIN_BANK: begin
						if (!odd) begin
							bsel_q         <= in_ch.data[2:0];
							mode_swap_q    <= in_ch.data[6];
							mode_chr_inv_q <= in_ch.data[7];
						end
					end
					WIN_MIRROR: begin
						if (!odd) begin
							if (!cfg.four_screen) mirror_q <= ~in_ch.data[0];
						end else begin
							protect_q <= in_ch.data[6];
						end
					end
					WIN_IRQ: begin
						if (!odd) irq_latch_q <= in_ch.data;
						else      irq_count_q <= '1;
					end
					WIN_IRQ_EN: irq_on_q <= odd;
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res_d;
			dbl_q <= dbl_d;
		end else if (mod_rsp.done) begin
			res_q.copy_bank <= dbl_q ? {mod_rsp.rem, 1'b0} : {1'b0, mod_rsp.rem};
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else         st_q <= st_d;
	end

	// next state and handshakes
	always_comb begin
		st_d         = st_q;
		in_ch.ready  = 1'b0;
		out_ch.valid = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) st_d = bank_wr ? ST_MOD : ST_DONE;
			end
			ST_MOD: begin
				if (mod_rsp.done) st_d = ST_DONE;
			end
			ST_DONE: begin
				out_ch.valid = 1'b1;
				if (out_ch.ready) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign out_ch.irq_assert     = res_q.irq_assert;
	assign out_ch.mirroring      = mirror_q;
	assign out_ch.write_suppress = res_q.write_suppress;
	assign out_ch.swap_prg       = res_q.swap_prg;
	assign out_ch.copy_kind      = res_q.copy_kind;
	assign out_ch.copy_dest      = res_q.copy_dest;
	assign out_ch.copy_bank      = res_q.copy_bank;
	assign out_ch.copy_len       = res_q.copy_len;

endmodule

// ===== sv/bank_mapper_scanline_irq.sv =====
// ---------------------------------------------------------------------------
// bank_mapper_scanline_irq
// Cartridge bank mapper with scanline interrupt counter.
//
//   channel  dir  beat
//   in_ch    in   func, address, data (CPU write or scanline clock)
//   out_ch   out  irq, mirroring, suppress, swap, bank load command
//   cfg_*    in   bank counts and four-screen flag, write only
//
// One result beat per input beat. Bank data writes run through the
// bit-serial modulo unit: the result is valid after its eight modulo steps
// and a capture of the remainder into the result register. All other
// beats show their result on the cycle after accept. One item is
// in flight: in_ch.ready is high only once the previous result beat has
// been taken, so a stalled out_ch stalls in_ch.
// Reset clears all mapper state; bank counts return to 1.
// ---------------------------------------------------------------------------
module bank_mapper_scanline_irq (
	input  logic                            clk,
	input  logic                            arst_n,
	bmsi_in_if.sink                         in_ch,
	bmsi_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [bmsi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmsi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bmsi_pkg::*;

	bmsi_cfg_t     cfg_q;
	bmsi_mod_req_t mod_req;
	bmsi_mod_rsp_t mod_rsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chr_count   <= 9'd1;
			cfg_q.prg_count   <= 9'd1;
			cfg_q.four_screen <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHR_COUNT:   cfg_q.chr_count   <= cfg_wdata;
				CFG_PRG_COUNT:   cfg_q.prg_count   <= cfg_wdata;
				CFG_FOUR_SCREEN: cfg_q.four_screen <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	bmsi_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.mod_req (mod_req),
		.mod_rsp (mod_rsp)
	);

	bmsi_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

endmodule
